// ===== rtl/core/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

   // Field widths of the token stream.
   localparam int POS_WIDTH      = 24;
   localparam int LINE_WIDTH     = 20;
   localparam int LEN_WIDTH      = 16;
   localparam int WORD_CHARS_DEF = 7;

   // Reserved word table shape.
   localparam int RES_COUNT   = 9;
   localparam int RES_MAX_LEN = 7;

   // Up to three tokens come out of one source byte.
   localparam int SLOTS       = 3;
   localparam int SLOT_WIDTH  = $clog2(SLOTS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Characters the decoder looks for.
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;

   // Word codes carried on keyword and comparator tokens.
   localparam logic [3:0] CODE_NONE    = 4'd0;
   localparam logic [3:0] CODE_EXIT    = 4'd1;
   localparam logic [3:0] CODE_INT     = 4'd2;
   localparam logic [3:0] CODE_IF      = 4'd3;
   localparam logic [3:0] CODE_WHILE   = 4'd4;
   localparam logic [3:0] CODE_WRITE   = 4'd5;
   localparam logic [3:0] CODE_EQ      = 4'd6;
   localparam logic [3:0] CODE_NEQ     = 4'd7;
   localparam logic [3:0] CODE_LESS    = 4'd8;
   localparam logic [3:0] CODE_GREATER = 4'd9;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_DIGITS,
      MODE_LETTERS,
      MODE_STRING
   } run_mode_type;

   typedef enum logic [2:0] {
      KIND_INT,
      KIND_KEYWORD,
      KIND_SEPARATOR,
      KIND_IDENT,
      KIND_STRING,
      KIND_COMPARATOR,
      KIND_END,
      KIND_OPEN_STRING
   } token_kind_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      token_kind_type          token_kind;
      logic [3:0]              word_code;
      logic [7:0]              sep_char;
      logic [POS_WIDTH-1:0]    start_offset;
      logic [LEN_WIDTH-1:0]    token_length;
      logic [LINE_WIDTH-1:0]   line_index;
      logic                    stream_done;
   } rsp_type;

   // All tokens caused by one source byte, in slot order.
   typedef struct packed {
      logic [SLOTS-1:0]        mask;
      rsp_type [SLOTS-1:0]     slot;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Reserved word text, left aligned, first character in the top byte.
   function automatic logic [RES_MAX_LEN*8-1:0] res_text(input logic [3:0] code);
      logic [RES_MAX_LEN*8-1:0] text;
      unique case (code)
         CODE_EXIT:    text = {"exit", 24'd0};
         CODE_INT:     text = {"int", 32'd0};
         CODE_IF:      text = {"if", 40'd0};
         CODE_WHILE:   text = {"while", 16'd0};
         CODE_WRITE:   text = {"write", 16'd0};
         CODE_EQ:      text = {"eq", 40'd0};
         CODE_NEQ:     text = {"neq", 32'd0};
         CODE_LESS:    text = {"less", 24'd0};
         CODE_GREATER: text = "greater";
         default:      text = '0;
      endcase
      return text;
   endfunction

   function automatic logic [3:0] res_len(input logic [3:0] code);
      logic [3:0] len;
      unique case (code)
         CODE_EXIT:    len = 4'd4;
         CODE_INT:     len = 4'd3;
         CODE_IF:      len = 4'd2;
         CODE_WHILE:   len = 4'd5;
         CODE_WRITE:   len = 4'd5;
         CODE_EQ:      len = 4'd2;
         CODE_NEQ:     len = 4'd3;
         CODE_LESS:    len = 4'd4;
         CODE_GREATER: len = 4'd7;
         default:      len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stt_front.sv =====
`default_nettype none

module stt_front
   import stt_pkg::*;
#(
   parameter int WORD_CHARS = WORD_CHARS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire req_type    req,
   output logic            push,
   output bundle_type      bundle
);

   typedef logic [WORD_CHARS-1:0][7:0] letters_type;

   run_mode_type           mode_ff, mode_in;
   logic [POS_WIDTH-1:0]   start_ff, start_in;
   logic [LEN_WIDTH-1:0]   len_ff, len_in;
   logic [LINE_WIDTH-1:0]  line_ff, line_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   letters_type            letters_ff, letters_in;
   logic                   stopped_ff, stopped_in;

   // Reserved word lookup over the first letters of a run.
   function automatic logic [3:0] match_word(input letters_type letters,
                                             input logic [LEN_WIDTH-1:0] len);
      logic [3:0]               code;
      logic                     hit;
      logic [RES_MAX_LEN*8-1:0] text;
      logic [3:0]               rlen;
      code = CODE_NONE;
      for (int c = 1; c <= RES_COUNT; c++) begin
         text = res_text(4'(c));
         rlen = res_len(4'(c));
         hit  = (len == LEN_WIDTH'(rlen));
         for (int j = 0; j < RES_MAX_LEN; j++) begin
            if ((4'(j) < rlen) && (letters[j] != text[8*(RES_MAX_LEN-1-j) +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            code = 4'(c);
         end
      end
      return code;
   endfunction

   // Token for a run that is closed by something other than its own end.
   function automatic rsp_type close_token(input run_mode_type mode,
                                           input logic [3:0] code,
                                           input logic [POS_WIDTH-1:0] start,
                                           input logic [LEN_WIDTH-1:0] len,
                                           input logic [LINE_WIDTH-1:0] line);
      rsp_type t;
      t = '0;
      t.start_offset = start;
      t.token_length = len;
      t.line_index   = line;
      unique case (mode)
         MODE_DIGITS: t.token_kind = KIND_INT;
         MODE_LETTERS: begin
            t.word_code = code;
            if (code == CODE_NONE) begin
               t.token_kind = KIND_IDENT;
            end else if (code <= CODE_WRITE) begin
               t.token_kind = KIND_KEYWORD;
            end else begin
               t.token_kind = KIND_COMPARATOR;
            end
         end
         MODE_STRING: t.token_kind = KIND_OPEN_STRING;
         default: t.token_kind = KIND_INT;
      endcase
      return t;
   endfunction

   function automatic rsp_type end_token(input logic [POS_WIDTH-1:0] start,
                                         input logic [LINE_WIDTH-1:0] line);
      rsp_type t;
      t = '0;
      t.token_kind   = KIND_END;
      t.start_offset = start;
      t.line_index   = line;
      t.stream_done  = 1'b1;
      return t;
   endfunction

   logic [7:0]            b;
   logic                  is_nul, is_quote, is_newline, is_digit, is_alpha, is_sep;
   logic [POS_WIDTH-1:0]  pos_next;
   logic [LEN_WIDTH-1:0]  len_next;
   logic                  used;

   // Byte classes.
   always_comb begin
      b          = req.byte_in;
      is_nul     = (b == CHAR_NUL);
      is_quote   = (b == CHAR_QUOTE);
      is_newline = (b == CHAR_NEWLINE);
      is_digit   = (b >= "0") && (b <= "9");
      is_alpha   = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
      is_sep     = (b == ";") || (b == ",") || (b == "(") || (b == ")") ||
                   (b == "{") || (b == "}") || (b == "=") || (b == "+") ||
                   (b == "-") || (b == "*") || (b == "/") || (b == "%");
      pos_next   = (&pos_ff) ? pos_ff : pos_ff + POS_WIDTH'(1);
      len_next   = (&len_ff) ? len_ff : len_ff + LEN_WIDTH'(1);
   end

   // Run tracking and token building for one accepted byte.
   always_comb begin
      mode_in    = mode_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      line_in    = line_ff;
      pos_in     = pos_ff;
      letters_in = letters_ff;
      stopped_in = stopped_ff;
      bundle     = '0;
      used       = 1'b0;

      if (take && !stopped_ff) begin
         pos_in = pos_next;
         if (is_nul) begin
            bundle.slot[0] = close_token(mode_ff, match_word(letters_ff, len_ff),
                                         start_ff, len_ff, line_ff);
            bundle.mask[0] = (mode_ff != MODE_IDLE);
            bundle.slot[2] = end_token(pos_ff, line_ff);
            bundle.mask[2] = 1'b1;
            mode_in        = MODE_IDLE;
            stopped_in     = 1'b1;
         end else begin
            // Continue or close the open run.
            unique case (mode_ff)
               MODE_STRING: begin
                  used = 1'b1;
                  if (is_quote) begin
                     bundle.slot[0] = close_token(mode_ff, CODE_NONE, start_ff,
                                                  len_ff, line_ff);
                     bundle.slot[0].token_kind = KIND_STRING;
                     bundle.mask[0] = 1'b1;
                     mode_in        = MODE_IDLE;
                  end else begin
                     len_in = len_next;
                  end
               end
               MODE_DIGITS: begin
                  if (is_digit) begin
                     used   = 1'b1;
                     len_in = len_next;
                  end else begin
                     bundle.slot[0] = close_token(mode_ff, CODE_NONE, start_ff,
                                                  len_ff, line_ff);
                     bundle.mask[0] = 1'b1;
                     mode_in        = MODE_IDLE;
                  end
               end
               MODE_LETTERS: begin
                  if (is_alpha) begin
                     used   = 1'b1;
                     len_in = len_next;
                     for (int i = 0; i < WORD_CHARS; i++) begin
                        if (len_ff == LEN_WIDTH'(i)) begin
                           letters_in[i] = b;
                        end
                     end
                  end else begin
                     bundle.slot[0] = close_token(mode_ff, match_word(letters_ff, len_ff),
                                                  start_ff, len_ff, line_ff);
                     bundle.mask[0] = 1'b1;
                     mode_in        = MODE_IDLE;
                  end
               end
               default: ;
            endcase

            // The byte stands on its own.
            if (!used) begin
               if (is_sep) begin
                  bundle.slot[1]              = '0;
                  bundle.slot[1].token_kind   = KIND_SEPARATOR;
                  bundle.slot[1].sep_char     = b;
                  bundle.slot[1].start_offset = pos_ff;
                  bundle.slot[1].token_length = LEN_WIDTH'(1);
                  bundle.slot[1].line_index   = line_ff;
                  bundle.mask[1]              = 1'b1;
               end else if (is_quote) begin
                  mode_in  = MODE_STRING;
                  start_in = pos_next;
                  len_in   = '0;
               end else if (is_digit) begin
                  mode_in  = MODE_DIGITS;
                  start_in = pos_ff;
                  len_in   = LEN_WIDTH'(1);
               end else if (is_alpha) begin
                  mode_in       = MODE_LETTERS;
                  start_in      = pos_ff;
                  len_in        = LEN_WIDTH'(1);
                  letters_in[0] = b;
               end else if (is_newline && !(&line_ff)) begin
                  line_in = line_ff + LINE_WIDTH'(1);
               end
            end

            // Last byte: close what is open and end the stream.
            if (req.final_byte) begin
               if (mode_in != MODE_IDLE) begin
                  bundle.slot[1] = close_token(mode_in, match_word(letters_in, len_in),
                                               start_in, len_in, line_in);
                  bundle.mask[1] = 1'b1;
               end
               bundle.slot[2] = end_token(pos_next, line_in);
               bundle.mask[2] = 1'b1;
               mode_in        = MODE_IDLE;
               stopped_in     = 1'b1;
            end
         end
      end
      push = |bundle.mask;
   end

   // Tokenizer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         start_ff   <= '0;
         len_ff     <= '0;
         line_ff    <= '0;
         pos_ff     <= '0;
         letters_ff <= '0;
         stopped_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         start_ff   <= start_in;
         len_ff     <= len_in;
         line_ff    <= line_in;
         pos_ff     <= pos_in;
         letters_ff <= letters_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/stt_queue.sv =====
`default_nettype none

module stt_queue
   import stt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire bundle_type  push_data,
   input  wire logic        pop,
   output bundle_type       head,
   output queue_status_type status
);

   bundle_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      status.full  = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      head         = entry_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in     = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Bundle storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/stt_back.sv =====
`default_nettype none

module stt_back
   import stt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type status,
   input  wire bundle_type       head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data
);

   logic [SLOTS-1:0]          mask_ff, mask_in;
   rsp_type [SLOTS-1:0]       slot_ff, slot_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_data_ff, out_data_in;

   logic                      out_free;
   logic                      emit;
   logic [SLOT_WIDTH-1:0]     sel;
   logic [SLOTS-1:0]          mask_after;

   // Send the lowest pending slot of the current bundle, then fetch the next one.
   always_comb begin
      sel = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = SLOT_WIDTH'(i);
         end
      end
      out_free   = !out_valid_ff || rsp_ready;
      emit       = out_free && (|mask_ff);
      mask_after = mask_ff;
      if (emit) begin
         mask_after[sel] = 1'b0;
      end
      pop          = (mask_after == '0) && !status.empty;
      mask_in      = pop ? head.mask : mask_after;
      slot_in      = pop ? head.slot : slot_ff;
      out_valid_in = emit || (out_valid_ff && !rsp_ready);
      out_data_in  = emit ? slot_ff[sel] : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/source_text_tokenizer.sv =====
// Source text tokenizer.
// The req channel takes one source byte per transaction, with a flag on the last
// byte. The rsp channel gives tokens: kind, word code, separator character, start
// offset, length and line. A NUL byte or the flagged last byte closes any open run
// and is followed by an end token with stream_done set; later bytes are taken and
// ignored until reset.
// Throughput: one byte per cycle on req while the token queue is not full, and
// one token per cycle on rsp while rsp_ready is high. A byte may give up to three
// tokens, so text dense in tokens is limited by the rsp side.
// Path: a byte's tokens are written into a four-entry token queue when the byte
// is taken, then move into the back end's slot register and on to the rsp register.
// When the receiver stalls, the queue fills and req_ready drops once it holds four
// bundles; nothing is lost.
// Reset (synchronous, active high) clears the run state, the position and line
// counters and every queued token.
// WORD_CHARS sets how many letters of a word are kept for reserved word matching.
`default_nettype none

module source_text_tokenizer
   import stt_pkg::*;
#(
   parameter int WORD_CHARS = WORD_CHARS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic             take;
   logic             push;
   logic             pop;
   bundle_type       push_data;
   bundle_type       head;
   queue_status_type status;

   // Accept whenever the queue has room for this byte's tokens.
   assign req_ready = !status.full;
   assign take      = req_valid && req_ready;

   stt_front #(
      .WORD_CHARS(WORD_CHARS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .push  (push),
      .bundle(push_data)
   );

   stt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .status   (status)
   );

   stt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .head     (head),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Nothing follows the end token.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.stream_done) |=> !rsp_valid)
      else $error("token delivered after the end token");

   // Only the end token carries stream_done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.token_kind == KIND_END) == rsp_data.stream_done))
      else $error("stream_done does not match the end token");

   // A separator token is one nonzero character long.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.token_kind == KIND_SEPARATOR)) |->
         ((rsp_data.token_length == LEN_WIDTH'(1)) && (rsp_data.sep_char != 8'd0)))
      else $error("malformed separator token");

   // The queue never pops when empty nor pushes when full.
   assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty) && !(push && status.full))
      else $error("token queue overrun or underrun");

endmodule

`default_nettype wire

// ===== tb/sv/stt_tb_pkg.sv =====
package stt_tb_pkg;
   import stt_pkg::*;

   // Expected token stream of the tokenizer, worked out byte by byte.
   class token_scoreboard;
      run_mode_type            mode;
      logic [POS_WIDTH-1:0]    run_start;
      logic [LEN_WIDTH-1:0]    run_len;
      logic [LINE_WIDTH-1:0]   line_cnt;
      logic [POS_WIDTH-1:0]    byte_pos;
      logic [7:0]              letters [WORD_CHARS_DEF];
      bit                      stopped;
      rsp_type                 expected_tokens [$];
      int                      errors;

      string reserved_words [RES_COUNT] = '{"exit", "int", "if", "while", "write",
                                            "eq", "neq", "less", "greater"};
      logic [3:0] reserved_codes [RES_COUNT] = '{CODE_EXIT, CODE_INT, CODE_IF,
                                                 CODE_WHILE, CODE_WRITE, CODE_EQ,
                                                 CODE_NEQ, CODE_LESS, CODE_GREATER};

      function new();
         mode      = MODE_IDLE;
         run_start = '0;
         run_len   = '0;
         line_cnt  = '0;
         byte_pos  = '0;
         stopped   = 1'b0;
         errors    = 0;
         foreach (letters[i]) letters[i] = '0;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      // Offsets stick at their maximum instead of wrapping.
      function logic [POS_WIDTH-1:0] next_pos(logic [POS_WIDTH-1:0] p);
         return (p == '1) ? p : p + 1'b1;
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function bit is_alpha(logic [7:0] b);
         return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      endfunction

      function bit is_sep(logic [7:0] b);
         return b inside {";", ",", "(", ")", "{", "}", "=", "+", "-", "*", "/", "%"};
      endfunction

      function void add_token(token_kind_type kind, logic [3:0] code, logic [7:0] sep,
                              logic [POS_WIDTH-1:0] start, logic [LEN_WIDTH-1:0] len,
                              bit done);
         rsp_type t;
         t.token_kind   = kind;
         t.word_code    = code;
         t.sep_char     = sep;
         t.start_offset = start;
         t.token_length = len;
         t.line_index   = line_cnt;
         t.stream_done  = done;
         expected_tokens.insert(expected_tokens.size(), t);
      endfunction

      // A word longer than the kept letters can never be reserved.
      function logic [3:0] word_code_of_run();
         bit hit;
         if (run_len > WORD_CHARS_DEF) return CODE_NONE;
         for (int k = 0; k < RES_COUNT; k++) begin
            if (reserved_words[k].len() == run_len) begin
               hit = 1'b1;
               for (int i = 0; i < reserved_words[k].len(); i++) begin
                  if (letters[i] != reserved_words[k][i]) hit = 1'b0;
               end
               if (hit) return reserved_codes[k];
            end
         end
         return CODE_NONE;
      endfunction

      function void close_run();
         logic [3:0] code;
         case (mode)
            MODE_DIGITS: begin
               add_token(KIND_INT, CODE_NONE, '0, run_start, run_len, 1'b0);
            end
            MODE_LETTERS: begin
               code = word_code_of_run();
               if (code == CODE_NONE)
                  add_token(KIND_IDENT, CODE_NONE, '0, run_start, run_len, 1'b0);
               else if (code <= CODE_WRITE)
                  add_token(KIND_KEYWORD, code, '0, run_start, run_len, 1'b0);
               else
                  add_token(KIND_COMPARATOR, code, '0, run_start, run_len, 1'b0);
            end
            MODE_STRING: begin
               add_token(KIND_OPEN_STRING, CODE_NONE, '0, run_start, run_len, 1'b0);
            end
            default: ;
         endcase
         mode = MODE_IDLE;
      endfunction

      function void extend_run(logic [7:0] b);
         if (mode == MODE_LETTERS && run_len < WORD_CHARS_DEF) letters[run_len] = b;
         if (run_len != '1) run_len++;
      endfunction

      function void begin_run(run_mode_type m, logic [POS_WIDTH-1:0] start);
         mode      = m;
         run_start = start;
         run_len   = '0;
      endfunction

      // Work out the tokens caused by one accepted source byte.
      function void note_byte(req_type item);
         logic [7:0]           b;
         logic [POS_WIDTH-1:0] p;
         bit                   used;
         if (stopped) return;
         b        = item.byte_in;
         p        = byte_pos;
         used     = 1'b0;
         byte_pos = next_pos(p);

         // NUL is not text: close the run and end at the NUL's own offset.
         if (b == CHAR_NUL) begin
            close_run();
            add_token(KIND_END, CODE_NONE, '0, p, '0, 1'b1);
            stopped = 1'b1;
            return;
         end

         // Continue the open run if this byte belongs to it.
         case (mode)
            MODE_STRING: begin
               if (b == CHAR_QUOTE) begin
                  add_token(KIND_STRING, CODE_NONE, '0, run_start, run_len, 1'b0);
                  mode = MODE_IDLE;
               end else begin
                  extend_run(b);
               end
               used = 1'b1;
            end
            MODE_DIGITS: begin
               if (is_digit(b)) begin
                  extend_run(b);
                  used = 1'b1;
               end else begin
                  close_run();
               end
            end
            MODE_LETTERS: begin
               if (is_alpha(b)) begin
                  extend_run(b);
                  used = 1'b1;
               end else begin
                  close_run();
               end
            end
            default: ;
         endcase

         // A byte that ended a run, or came with no run open, is classified on its own.
         if (!used) begin
            if (is_sep(b)) begin
               add_token(KIND_SEPARATOR, CODE_NONE, b, p, 16'd1, 1'b0);
            end else if (b == CHAR_QUOTE) begin
               begin_run(MODE_STRING, next_pos(p));
            end else if (is_digit(b)) begin
               begin_run(MODE_DIGITS, p);
               extend_run(b);
            end else if (is_alpha(b)) begin
               begin_run(MODE_LETTERS, p);
               extend_run(b);
            end else if (b == CHAR_NEWLINE) begin
               if (line_cnt != '1) line_cnt++;
            end
         end

         // The last byte counts as text, then the stream ends one past it.
         if (item.final_byte) begin
            close_run();
            add_token(KIND_END, CODE_NONE, '0, next_pos(p), '0, 1'b1);
            stopped = 1'b1;
         end
      endfunction

      function string show(rsp_type t);
         return $sformatf("kind %0d code %0d sep %02h start %0d len %0d line %0d done %0b",
                          t.token_kind, t.word_code, t.sep_char, t.start_offset,
                          t.token_length, t.line_index, t.stream_done);
      endfunction

      // Compare one delivered token with the oldest expected one.
      function void check_token(rsp_type got);
         rsp_type want;
         if (expected_tokens.size() == 0) begin
            errors++;
            if (errors <= 10) $display("token with none expected: %s", show(got));
            return;
         end
         want = expected_tokens.pop_front();
         if (got.token_kind !== want.token_kind || got.word_code !== want.word_code ||
             got.sep_char !== want.sep_char || got.start_offset !== want.start_offset ||
             got.token_length !== want.token_length ||
             got.line_index !== want.line_index ||
             got.stream_done !== want.stream_done) begin
            errors++;
            if (errors <= 10) begin
               $display("token mismatch: expected %s", show(want));
               $display("                got      %s", show(got));
            end
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import stt_pkg::*;
   import stt_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 80;
   localparam int HOLD_CYCLES  = 60;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int phase     = 0;
   int cycles    = 0;
   int sent      = 0;
   int kw_turn   = 0;
   int sep_turn  = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   token_scoreboard board = new();

   string keywords [9] = '{"exit", "int", "if", "while", "write",
                           "eq", "neq", "less", "greater"};
   string separators = ";,(){}=+-*/%";

   source_text_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** source_text_tokenizer: FAILED **");
         $finish;
      end
   end

   // Receiver: random stalls per phase, plus one long hold-off when the
   // idle-free phase starts so that the token queue fills and req_ready drops.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (phase == 2 && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= (phase == 0 ? 81 : phase == 1 ? 27 : 0));
         end
      end
   end

   // Every accepted token transaction is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_token(rsp_data);
   end

   function automatic logic [7:0] random_letter();
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
   endfunction

   // Offer one byte, starting and ending at a falling edge.
   task automatic send_byte(input logic [7:0] value, input logic last);
      int idle_pct;
      idle_pct = (phase == 0) ? 27 : (phase == 1) ? 81 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{byte_in: value, final_byte: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_byte(req_data);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], 1'b0);
   endtask

   // One well-formed token with random content, or a bit of noise, then
   // an optional gap. Keywords and separators rotate so that all show up.
   task automatic random_token();
      string      word;
      logic [7:0] c;
      case ($urandom_range(9))
         0, 1, 2: begin
            word = keywords[kw_turn % 9];
            kw_turn++;
            // Near misses: cut short, one letter too many, or capitalized.
            case ($urandom_range(7))
               0: word = word.substr(0, word.len() - 2);
               1: word = {word, "s"};
               2: word.putc(0, word[0] - 8'd32);
               default: ;
            endcase
            send_text(word);
         end
         3, 4: begin
            send_byte(separators[sep_turn % 12], 1'b0);
            sep_turn++;
         end
         5: repeat ($urandom_range(1, 10)) send_byte(random_letter(), 1'b0);
         6: repeat ($urandom_range(1, 5)) send_byte(8'h30 + 8'($urandom_range(9)), 1'b0);
         7: begin
            send_byte(CHAR_QUOTE, 1'b0);
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom_range(1, 255));
               if (c == CHAR_QUOTE) c = CHAR_NEWLINE;
               send_byte(c, 1'b0);
            end
            send_byte(CHAR_QUOTE, 1'b0);
         end
         8: begin
            c = 8'($urandom_range(1, 255));
            if (c == CHAR_QUOTE) c = 8'h7F;
            send_byte(c, 1'b0);
         end
         default: send_byte(CHAR_NEWLINE, 1'b0);
      endcase
      case ($urandom_range(3))
         1: send_byte(" ", 1'b0);
         2: send_byte(CHAR_NEWLINE, 1'b0);
         3: send_byte(8'h09, 1'b0);
         default: ;
      endcase
   endtask

   initial begin
      int base;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: the longest comparator, a case near miss, a digit run ended
      // by a letter, a string holding a newline and a high byte, skipped bytes.
      send_text("greater Int9x;");
      send_text("\"a\n");
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h01, 1'b0);
      send_text("\n(12)");

      // Random text, through the three idling phases.
      base = sent;
      while (sent - base < RANDOM_ITEMS || kw_turn < 9 || sep_turn < 12) begin
         phase = (sent - base) * 3 / RANDOM_ITEMS;
         if (phase > 2) phase = 2;
         random_token();
      end

      // End the text, sometimes inside a string, by NUL or by the last flag.
      if ($urandom_range(1)) begin
         send_byte(CHAR_QUOTE, 1'b0);
         send_byte("q", 1'b0);
      end
      if ($urandom_range(2) == 0) send_byte(CHAR_NUL, 1'($urandom_range(1)));
      else send_byte(8'($urandom_range(1, 255)), 1'b1);

      // Bytes after the end token are taken and dropped.
      repeat (3) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      send_byte(8'($urandom_range(255)), 1'b1);
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("** source_text_tokenizer: PASSED **");
      end else begin
         $display("** source_text_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule
